FILE: hw/rtl/gng_pkg.sv
// shared widths, codes and types of the grid neighbor generator
package gng_pkg;

    // field widths
    localparam int IDX_W     = 12;  // cell and neighbor index
    localparam int DIM_W     = 13;  // grid rows and columns
    localparam int CAND_W    = 14;  // candidate index before range check
    localparam int CFG_IDX_W = 2;

    // neighbor slots, ascending in index order
    localparam int NUM_SLOTS = 6;
    localparam int SLOT_W    = 3;

    // divider steps, one quotient bit each
    localparam int DIV_STEPS = IDX_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOK_MODE = 2'd2;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [CAND_W-1:0]    t_cand;
    typedef logic [NUM_SLOTS-1:0] t_mask;

endpackage

FILE: hw/rtl/gng_ifs.sv
// request and response channels of the grid neighbor generator
interface gng_req_if import gng_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [IDX_W-1:0] cell_index;
    logic             cell_has_data;

    modport source (output valid, cmd, cell_index, cell_has_data, input ready);
    modport sink (input valid, cmd, cell_index, cell_has_data, output ready);
endinterface

interface gng_rsp_if import gng_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] neighbor_index;
    logic             neighbor_found;
    logic             last;

    modport source (output valid, neighbor_index, neighbor_found, last, input ready);
    modport sink (input valid, neighbor_index, neighbor_found, last, output ready);
endinterface

FILE: hw/rtl/grid_neighbor_generator.sv
// grid neighbor generator: flag store, row/column divider, neighbor read and emit
// write item: flag stored at the accepting edge
// query item: accept, divider steps, setup, flag reads, wait, then one result per cycle while
//   the output is not stalled, 1 to 6 results for each query
// cell beyond the store or zero columns: straight to emit; no candidate: emit after setup
// synchronous reset: 1x1 grid, rook off, clearing pass over all flags, no item accepted
module grid_neighbor_generator import gng_pkg::*; #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    gng_req_if.sink              i_req,
    gng_rsp_if.source            o_rsp
);

    localparam int AW    = $clog2(MAX_CELLS);
    localparam int CMP_W = ((AW > CAND_W) ? AW : CAND_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CALC,
        S_READ,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic                 r_clr;
    logic [AW-1:0]        r_clr_addr;
    logic [DIM_W-1:0]     r_rows;
    logic [DIM_W-1:0]     r_cols;
    logic                 r_quad;
    logic [IDX_W-1:0]     r_cell;
    logic [IDX_W-1:0]     r_quo;
    logic [DIM_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_cand                r_cand [NUM_SLOTS];
    t_mask                r_en;
    t_mask                r_mask;
    logic [SLOT_W-1:0]    r_slot;
    logic [SLOT_W-1:0]    r_rd_slot;
    logic                 r_pend;
    logic                 r_rdata;
    logic                 r_mem [MAX_CELLS];
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_index;
    logic                 r_out_found;
    logic                 r_out_last;

    logic                 in_acc;
    logic [CMP_W-1:0]     in_ext;
    logic                 in_store;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_wdata;
    logic [CMP_W-1:0]     rd_ext;
    logic [AW-1:0]        mem_raddr;
    logic [CAND_W-1:0]    rem_sh;
    logic                 div_ge;
    logic [CAND_W-1:0]    rem_diff;
    t_cand                n_cand [NUM_SLOTS];
    t_mask                n_en;
    logic [SLOT_W-1:0]    pick;
    t_mask                pick_oh;
    t_mask                rest;

    // input handshake and store range of the item's cell
    assign i_req.ready = (r_state == S_IDLE) && !r_clr;
    assign in_acc      = i_req.valid && i_req.ready;
    assign in_ext      = CMP_W'(i_req.cell_index);
    assign in_store    = in_ext < CMP_W'(MAX_CELLS);

    // memory port selection: clearing pass or item write
    assign mem_we    = r_clr || (in_acc && (i_req.cmd == CMD_WRITE) && in_store);
    assign mem_waddr = r_clr ? r_clr_addr : in_ext[AW-1:0];
    assign mem_wdata = r_clr ? 1'b0 : i_req.cell_has_data;
    assign rd_ext    = CMP_W'(r_cand[0]);
    assign mem_raddr = rd_ext[AW-1:0];

    // flag memory, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // restoring divider step: one quotient bit per cycle
    assign rem_sh   = {r_rem, r_quo[IDX_W-1]};
    assign div_ge   = rem_sh >= {1'b0, r_cols};
    assign rem_diff = rem_sh - {1'b0, r_cols};

    // candidate indexes and enables from row and column
    always_comb begin
        logic             s;
        logic             row_ok;
        logic             up_ok;
        logic             dn_ok;
        logic             left_ok;
        logic             right_ok;
        logic             col_a_ok;
        logic             col_b_ok;
        t_cand            cell_w;
        t_cand            cols_w;
        t_cand            s_w;
        t_cand            up_base;
        t_cand            dn_base;
        logic [DIM_W-1:0] row_w;

        row_w    = DIM_W'(r_quo);
        s        = r_quo[0] && !r_quad;
        row_ok   = row_w < r_rows;
        up_ok    = r_quo != '0;
        dn_ok    = (row_w + DIM_W'(1)) < r_rows;
        left_ok  = r_rem != '0;
        right_ok = ({1'b0, r_rem} + CAND_W'(1)) < {1'b0, r_cols};
        col_a_ok = !(s && (r_rem == '0));
        col_b_ok = s || right_ok;
        cell_w   = CAND_W'(r_cell);
        cols_w   = {1'b0, r_cols};
        s_w      = CAND_W'(s);
        up_base  = cell_w - cols_w;
        dn_base  = cell_w + cols_w;

        n_cand[0] = up_base - s_w;
        n_cand[1] = up_base + CAND_W'(1) - s_w;
        n_cand[2] = cell_w - CAND_W'(1);
        n_cand[3] = cell_w + CAND_W'(1);
        n_cand[4] = dn_base - s_w;
        n_cand[5] = dn_base + CAND_W'(1) - s_w;

        n_en[0] = up_ok && col_a_ok;
        n_en[1] = !r_quad && up_ok && col_b_ok;
        n_en[2] = left_ok;
        n_en[3] = right_ok;
        n_en[4] = dn_ok && col_a_ok;
        n_en[5] = !r_quad && dn_ok && col_b_ok;

        // drop the whole query outside the grid, single candidates beyond the store
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_en[i] = n_en[i] && row_ok && (CMP_W'(n_cand[i]) < CMP_W'(MAX_CELLS));
        end
    end

    // highest surviving slot is the largest index
    always_comb begin
        pick    = '0;
        pick_oh = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (r_mask[i]) begin
                pick    = SLOT_W'(i);
                pick_oh = t_mask'(1) << i;
            end
        end
        rest = r_mask & ~pick_oh;
    end

    // control sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_rows      <= DIM_W'(1);
            r_cols      <= DIM_W'(1);
            r_quad      <= 1'b0;
            r_en        <= '0;
            r_mask      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GRID_ROWS: r_rows <= i_cfg_data;
                    CFG_GRID_COLS: r_cols <= i_cfg_data;
                    CFG_ROOK_MODE: r_quad <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // clearing pass
            if (r_clr) begin
                if (r_clr_addr == AW'(MAX_CELLS - 1)) begin
                    r_clr <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end

            // flag capture in the cycle after each read
            r_pend    <= (r_state == S_READ);
            r_rd_slot <= r_slot;
            if (r_pend) begin
                r_mask[r_rd_slot] <= r_rdata && r_en[r_rd_slot];
            end

            // result taken while no new one is produced
            if (o_rsp.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_req.cmd == CMD_QUERY)) begin
                        r_cell <= i_req.cell_index;
                        r_quo  <= i_req.cell_index;
                        r_rem  <= '0;
                        r_cnt  <= '0;
                        if ((r_cols == '0) || !in_store) begin
                            r_en    <= '0;
                            r_mask  <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? rem_diff[DIM_W-1:0] : rem_sh[DIM_W-1:0];
                    r_quo <= {r_quo[IDX_W-2:0], div_ge};
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_cand  <= n_cand;
                    r_en    <= n_en;
                    r_mask  <= '0;
                    r_slot  <= '0;
                    r_state <= (n_en == '0) ? S_EMIT : S_READ;
                end
                S_READ: begin
                    // rotate so the slot being read always sits at the head
                    for (int i = 0; i < NUM_SLOTS - 1; i++) begin
                        r_cand[i] <= r_cand[i+1];
                    end
                    r_cand[NUM_SLOTS-1] <= r_cand[0];
                    if (r_slot == SLOT_W'(NUM_SLOTS - 1)) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_slot <= r_slot + SLOT_W'(1);
                    end
                end
                S_WAIT: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        if (r_mask != '0) begin
                            r_out_index <= r_cand[pick][IDX_W-1:0];
                            r_out_found <= 1'b1;
                            r_out_last  <= (rest == '0);
                            r_mask      <= rest;
                            if (rest == '0) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_out_index <= '0;
                            r_out_found <= 1'b0;
                            r_out_last  <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // response channel
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.neighbor_index = r_out_index;
    assign o_rsp.neighbor_found = r_out_found;
    assign o_rsp.last           = r_out_last;

`ifndef SYNTHESIS
    // survivors only among enabled candidates
    a_mask_in_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask & ~r_en) == '0)
        else $error("survivor mask outside candidate enables");

    // a not-found result closes the query with a zero index
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.neighbor_found) |-> (o_rsp.last && (o_rsp.neighbor_index == '0)))
        else $error("not-found result without last or with nonzero index");

    // every read is captured before emitting starts
    a_emit_after_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_pend)
        else $error("emit while a flag read is outstanding");

    // a read issue is followed by its capture
    a_read_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> r_pend)
        else $error("flag read not captured");

    // no query in flight during the clearing pass
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> (r_state == S_IDLE))
        else $error("query in flight during clearing pass");
`endif

endmodule
